/* design/mcd_pkg.sv */
// ----------------------------------------------------------------------------
// mcd_pkg: shared types and constants of the multi-channel debouncer
// Item structs, configuration register indexes and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package mcd_pkg;

  // Channels that the item fields can carry
  localparam int unsigned MaxCh   = 8;
  localparam int unsigned ChIdxW  = 3;
  localparam int unsigned CountW  = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgDebounce = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgChCount  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDetect   = 2'd2;

  // Reset values of the configuration registers
  localparam logic [15:0]       DebounceRst = 16'd50;
  localparam logic [CountW-1:0] ChCountRst  = 4'd8;
  localparam logic              DetectRst   = 1'b0;

  typedef struct packed {
    logic [7:0]  raw_levels;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [3:0] channel_number;
    logic       detected;
    logic [7:0] stable_map;
    logic       last;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic              capture;  // register the accepted sample
    logic              prime;    // first sample: load raw and stable levels
    logic              proc;     // debounce channel idx
    logic              emit;     // load result register from channel idx
    logic [ChIdxW-1:0] idx;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic              primed;
    logic [CountW-1:0] n_active;
    logic              changed_at;  // channel idx changed in this sample
    logic              out_busy;    // result register full and not taken
  } stat_t;

endpackage

/* design/multi_channel_debouncer.sv */
// ----------------------------------------------------------------------------
// multi_channel_debouncer: timestamp debouncer for up to eight sensor inputs
// Top level: joins the sequencer and the datapath.
// ----------------------------------------------------------------------------
// Each input item is one sample of the raw channel levels plus the current
// millisecond time. The first sample after reset only loads the raw and
// stable levels of the channels in use and yields no item. After that, a
// channel whose raw level moved gets a fresh timestamp; once its raw level
// has held for strictly more than debounce_ms (32-bit wrapping difference)
// and differs from the stable level, the stable level follows it and one
// change item is produced: the 1-based channel number, whether the new level
// means detected, the detected map of all channels in use, and a last mark on
// the final change of the sample. Changes come out in ascending channel
// order. The first sample is primed without leaving the idle state. A later
// sample with n channels in use (n = min(channel_count, CHANNELS, 8)) makes
// two passes: one runs every channel through the single timestamp
// subtract-and-compare unit, and a second hands changed channels one per
// cycle, while the output side does not stall, to the single result register.
// A new sample is taken as soon as the sequencer is idle, even while the
// last change item still waits in the result register.
// Configuration writes are expected only while the block is idle.
// ----------------------------------------------------------------------------
module multi_channel_debouncer #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write port
  input  logic                        cfg_we_i,
  input  logic [mcd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [mcd_pkg::CfgW-1:0]    cfg_wdata_i,
  // sample items in
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  mcd_pkg::in_item_t           in_data_i,
  // change items out
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output mcd_pkg::out_item_t          out_data_o
);
  import mcd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer: accept a sample, sweep channels, then sweep out changes
  mcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath: config, levels, timestamps, debounce unit, result register
  mcd_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* design/mcd_ctrl.sv */
// ----------------------------------------------------------------------------
// mcd_ctrl: sequencer of the multi-channel debouncer
// Walks the channels in use once to debounce them, then once more to hand
// out one change item per changed channel.
// ----------------------------------------------------------------------------
module mcd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mcd_pkg::stat_t stat_i,
  output mcd_pkg::cmd_t  cmd_o
);
  import mcd_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StProc,
    StEmit
  } state_e;

  state_e            state_q, state_d;
  logic [ChIdxW-1:0] idx_q, idx_d;
  logic              last_idx;

  assign last_idx   = ({1'b0, idx_q} == (stat_i.n_active - 4'd1));
  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    cmd_o         = '0;
    cmd_o.idx     = idx_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (!stat_i.primed) begin
            cmd_o.prime = 1'b1;
          end else if (stat_i.n_active != '0) begin
            state_d = StProc;
            idx_d   = '0;
          end
        end
      end
      StProc: begin
        cmd_o.proc = 1'b1;
        if (last_idx) begin
          state_d = StEmit;
          idx_d   = '0;
        end else begin
          idx_d = idx_q + 3'd1;
        end
      end
      StEmit: begin
        // hold on a changed channel until the result register frees up
        if (!(stat_i.changed_at && stat_i.out_busy)) begin
          cmd_o.emit = stat_i.changed_at;
          if (last_idx) begin
            state_d = StIdle;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

/* design/mcd_dp.sv */
// ----------------------------------------------------------------------------
// mcd_dp: datapath of the multi-channel debouncer
// Configuration registers, level and timestamp state, one-channel debounce
// unit and the result register.
// ----------------------------------------------------------------------------
module mcd_dp #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mcd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [mcd_pkg::CfgW-1:0]      cfg_wdata_i,
  input  mcd_pkg::in_item_t             in_data_i,
  input  mcd_pkg::cmd_t                 cmd_i,
  output mcd_pkg::stat_t                stat_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output mcd_pkg::out_item_t            out_data_o
);
  import mcd_pkg::*;

  localparam int unsigned NumCh = (CHANNELS < MaxCh) ? CHANNELS : MaxCh;
  localparam int unsigned StW   = (NumCh > 1) ? $clog2(NumCh) : 1;

  logic [15:0]       debounce_q;
  logic [CountW-1:0] ch_count_q;
  logic              detect_q;

  logic [7:0]        raw_q;
  logic [31:0]       now_q;
  logic [7:0]        prev_q;
  logic [7:0]        stable_q;
  logic [7:0]        changed_q;
  logic              primed_q;
  logic [31:0]       stamp_q [NumCh];

  out_item_t         out_q;
  logic              out_valid_q;

  logic [CountW-1:0] n_active;
  logic [7:0]        used;
  logic [7:0]        map;
  logic [StW-1:0]    sidx;
  logic              cur, prev, stab;
  logic [31:0]       stamp_eff;
  logic [31:0]       elapsed;
  logic              hit;

  assign n_active = (ch_count_q < CountW'(NumCh)) ? ch_count_q : CountW'(NumCh);
  assign used     = (n_active >= 4'd8) ? 8'hFF : 8'((9'd1 << n_active) - 9'd1);
  assign map      = (detect_q ? stable_q : ~stable_q) & used;

  // One channel per cycle: stamp select, wrapping subtract, compare
  assign sidx      = cmd_i.idx[StW-1:0];
  assign cur       = raw_q[cmd_i.idx];
  assign prev      = prev_q[cmd_i.idx];
  assign stab      = stable_q[cmd_i.idx];
  assign stamp_eff = (cur != prev) ? now_q : stamp_q[sidx];
  assign elapsed   = now_q - stamp_eff;
  assign hit       = (elapsed > {16'd0, debounce_q}) && (cur != stab);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DebounceRst;
      ch_count_q <= ChCountRst;
      detect_q   <= DetectRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDebounce: debounce_q <= cfg_wdata_i;
        CfgChCount:  ch_count_q <= cfg_wdata_i[CountW-1:0];
        CfgDetect:   detect_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= '0;
      stable_q  <= '0;
      changed_q <= '0;
      primed_q  <= 1'b0;
      for (int i = 0; i < NumCh; i++) begin
        stamp_q[i] <= '0;
      end
    end else begin
      if (cmd_i.capture) begin
        changed_q <= '0;
      end
      if (cmd_i.prime) begin
        prev_q   <= (prev_q & ~used) | (in_data_i.raw_levels & used);
        stable_q <= (stable_q & ~used) | (in_data_i.raw_levels & used);
        primed_q <= 1'b1;
      end
      if (cmd_i.proc) begin
        prev_q[cmd_i.idx] <= cur;
        if (cur != prev) begin
          stamp_q[sidx] <= now_q;
        end
        if (hit) begin
          stable_q[cmd_i.idx]  <= cur;
          changed_q[cmd_i.idx] <= 1'b1;
        end
      end
    end
  end

  // Sample register, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      raw_q <= in_data_i.raw_levels;
      now_q <= in_data_i.now_ms;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.channel_number <= {1'b0, cmd_i.idx} + 4'd1;
      out_q.detected       <= map[cmd_i.idx];
      out_q.stable_map     <= map;
      out_q.last           <= ~|(changed_q & (8'hFE << cmd_i.idx));
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

  assign stat_o.primed     = primed_q;
  assign stat_o.n_active   = n_active;
  assign stat_o.changed_at = changed_q[cmd_i.idx];
  assign stat_o.out_busy   = out_valid_q && !out_ready_i;

endmodule

/* dv/multi_channel_debouncer_test.sv */
// ----------------------------------------------------------------------------
// multi_channel_debouncer_test: self-checking bench for the sensor debouncer
// A scripted opening checks priming, the hold-time boundaries, wrapping time
// stamps and every register setting. Random phases follow under changing
// configurations and handshake idling. Each change item is compared against
// a typed expectation or a cycle-free model of the debouncer in this bench.
// ----------------------------------------------------------------------------
module multi_channel_debouncer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mcd_pkg::*;

  localparam int unsigned Channels     = 8;
  localparam int unsigned ResetCycles  = 5;
  // leave margin for a sample to finish before touching registers
  localparam int unsigned SettleCycles = 2 * MaxCh + 8;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned QuietLimit   = 3000;
  localparam int unsigned MaxReports   = 10;

  typedef enum logic {RowCfg, RowSample} row_kind_e;

  // One line of the opening script: a register write or a sample, with the
  // expected change typed in where it is obvious.
  typedef struct packed {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] reg_idx;
    logic [CfgW-1:0]    reg_val;
    in_item_t           sample;
    logic               typed;
    logic [3:0]         typed_n;
    out_item_t          typed_change;
  } script_row_t;

  typedef struct packed {
    logic [15:0] hold;
    logic [3:0]  count;
    logic        detect;
    logic [6:0]  idle;
    logic [6:0]  stall;
    logic [7:0]  items;
    logic        pressure;
  } phase_t;

  localparam int unsigned NumRows = 27;
  localparam script_row_t Script [NumRows] = '{
    // prime with no channel in use: nothing loaded, nothing emitted
    '{RowCfg,    CfgChCount,  16'd0,     '0,                        1'b0, 4'd0, '0},
    '{RowSample, CfgDebounce, 16'd0,     '{8'hFF, 32'd0},           1'b1, 4'd0, '0},
    '{RowCfg,    CfgChCount,  16'd8,     '0,                        1'b0, 4'd0, '0},
    // rising bits get stamped, then accepted once 51 ms have passed
    '{RowSample, CfgDebounce, 16'd0,     '{8'hA5, 32'd10},          1'b1, 4'd0, '0},
    '{RowSample, CfgDebounce, 16'd0,     '{8'hA5, 32'd61},          1'b0, 4'd0, '0},
    // exactly the hold time is not enough, one more ms is
    '{RowSample, CfgDebounce, 16'd0,     '{8'hA4, 32'd1000},        1'b1, 4'd0, '0},
    '{RowSample, CfgDebounce, 16'd0,     '{8'hA4, 32'd1050},        1'b1, 4'd0, '0},
    '{RowSample, CfgDebounce, 16'd0,     '{8'hA4, 32'd1051},        1'b1, 4'd1,
      '{4'd1, 1'b1, 8'h5B, 1'b1}},
    // every channel flips and settles together
    '{RowSample, CfgDebounce, 16'd0,     '{8'h5B, 32'd2000},        1'b1, 4'd0, '0},
    '{RowSample, CfgDebounce, 16'd0,     '{8'h5B, 32'd2051},        1'b0, 4'd0, '0},
    // time stamp just below the wrap, hold measured across it
    '{RowSample, CfgDebounce, 16'd0,     '{8'h5A, 32'hFFFF_FFF0},   1'b1, 4'd0, '0},
    '{RowSample, CfgDebounce, 16'd0,     '{8'h5A, 32'h0000_0022},   1'b1, 4'd0, '0},
    '{RowSample, CfgDebounce, 16'd0,     '{8'h5A, 32'h0000_0023},   1'b1, 4'd1,
      '{4'd1, 1'b1, 8'hA5, 1'b1}},
    '{RowCfg,    CfgDetect,   16'd1,     '0,                        1'b0, 4'd0, '0},
    '{RowSample, CfgDebounce, 16'd0,     '{8'h00, 32'hFFFF_FFFF},   1'b0, 4'd0, '0},
    // zero hold time: accepted one ms after the change
    '{RowCfg,    CfgDebounce, 16'd0,     '0,                        1'b0, 4'd0, '0},
    '{RowSample, CfgDebounce, 16'd0,     '{8'h00, 32'd0},           1'b0, 4'd0, '0},
    // longest hold time
    '{RowCfg,    CfgDebounce, 16'd65535, '0,                        1'b0, 4'd0, '0},
    '{RowSample, CfgDebounce, 16'd0,     '{8'hFF, 32'd100},         1'b0, 4'd0, '0},
    '{RowSample, CfgDebounce, 16'd0,     '{8'hFF, 32'd65635},       1'b0, 4'd0, '0},
    '{RowSample, CfgDebounce, 16'd0,     '{8'hFF, 32'd65636},       1'b0, 4'd0, '0},
    // narrow to three channels, then widen past the limit
    '{RowCfg,    CfgChCount,  16'd3,     '0,                        1'b0, 4'd0, '0},
    '{RowSample, CfgDebounce, 16'd0,     '{8'h00, 32'd70000},       1'b0, 4'd0, '0},
    '{RowCfg,    CfgChCount,  16'd15,    '0,                        1'b0, 4'd0, '0},
    '{RowSample, CfgDebounce, 16'd0,     '{8'h00, 32'd200000},      1'b0, 4'd0, '0},
    '{RowSample, CfgDebounce, 16'd0,     '{8'h00, 32'd265536},      1'b0, 4'd0, '0},
    '{RowSample, CfgDebounce, 16'd0,     '{8'h81, 32'd265536},      1'b0, 4'd0, '0}
  };

  localparam int unsigned NumPhases = 7;
  localparam phase_t Phases [NumPhases] = '{
    '{16'd5,     4'd8,  1'b0, 7'd0,  7'd0,  8'd25, 1'b0},
    '{16'd0,     4'd15, 1'b1, 7'd77, 7'd0,  8'd30, 1'b0},
    '{16'd65535, 4'd8,  1'b0, 7'd0,  7'd77, 8'd20, 1'b0},
    '{16'd0,     4'd0,  1'b1, 7'd29, 7'd29, 8'd6,  1'b0},
    '{16'd12,    4'd1,  1'b1, 7'd29, 7'd29, 8'd20, 1'b0},
    '{16'd3,     4'd5,  1'b0, 7'd29, 7'd29, 8'd25, 1'b0},
    // receiver holds off while samples keep coming
    '{16'd2,     4'd8,  1'b1, 7'd0,  7'd0,  8'd30, 1'b1}
  };

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  in_item_t           in_data;
  logic               out_valid;
  logic               out_ready;
  out_item_t          out_data;

  // Model state and register copies
  logic [15:0]        hold_ms;
  logic [3:0]         ch_count;
  logic               detect_lvl;
  logic [7:0]         seen_raw;
  logic [7:0]         settled;
  logic [31:0]        moved_ms [Channels];
  logic               loaded;

  out_item_t          step_changes [MaxCh];
  out_item_t          due_changes [$];

  int unsigned        idle_pct;
  int unsigned        stall_pct;
  logic               hold_req;
  int unsigned        error_count;
  int unsigned        quiet_cycles;

  multi_channel_debouncer #(
    .CHANNELS(Channels)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Debounce one sample; leave its change items in step_changes and return
  // how many there are.
  function automatic int debounce_step(input in_item_t s);
    int unsigned n;
    logic [7:0]  used;
    logic [7:0]  changed;
    logic [7:0]  map;
    logic [31:0] held;
    int          cnt;
    n = (ch_count < Channels) ? ch_count : Channels;
    if (n > MaxCh) n = MaxCh;
    used = (n >= 8) ? 8'hFF : 8'((1 << n) - 1);
    changed = '0;
    cnt = 0;
    // first sample only loads the levels of the channels in use
    if (!loaded) begin
      seen_raw = (seen_raw & ~used) | (s.raw_levels & used);
      settled  = (settled & ~used) | (s.raw_levels & used);
      loaded   = 1'b1;
      return 0;
    end
    for (int i = 0; i < n; i++) begin
      if (s.raw_levels[i] != seen_raw[i]) moved_ms[i] = s.now_ms;
      held = s.now_ms - moved_ms[i];
      if (held > {16'd0, hold_ms} && s.raw_levels[i] != settled[i]) begin
        settled[i] = ~settled[i];
        changed[i] = 1'b1;
      end
      seen_raw[i] = s.raw_levels[i];
    end
    map = (detect_lvl ? settled : ~settled) & used;
    for (int i = 0; i < n; i++) begin
      if (changed[i]) begin
        step_changes[cnt] = '{4'(i + 1), map[i], map, 1'b0};
        cnt++;
      end
    end
    if (cnt != 0) step_changes[cnt - 1].last = 1'b1;
    return cnt;
  endfunction

  function automatic void flag_error(input string msg);
    if (error_count < MaxReports) $display("%t: %s", $realtime, msg);
    error_count++;
  endfunction

  // Drop valid and wait until every change item is out and the block has
  // finished any sample that produces none.
  task automatic settle();
    in_valid <= 1'b0;
    while (due_changes.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    settle();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CfgDebounce: hold_ms    = val;
      CfgChCount:  ch_count   = val[3:0];
      CfgDetect:   detect_lvl = val[0];
      default: ;
    endcase
  endtask

  // Offer one sample, wait for the handshake, then queue what it should
  // cause: the typed expectation if given, else the model's.
  task automatic offer(input in_item_t s, input logic typed, input logic [3:0] typed_n,
                       input out_item_t typed_change);
    int n;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n = debounce_step(s);
    if (typed) begin
      for (int k = 0; k < typed_n; k++) due_changes.push_back(typed_change);
    end else begin
      for (int k = 0; k < n; k++) due_changes.push_back(step_changes[k]);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off when asked for.
  initial begin : receiver
    int unsigned hold_left;
    logic        hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_seen) hold_left = HoldCycles;
      hold_seen = hold_req;
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Compare each accepted change item with the oldest one due.
  always @(posedge clk) begin : change_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_changes.size() == 0) begin
        flag_error($sformatf("unexpected change item: ch=%0d det=%0b map=%02h last=%0b",
                             out_data.channel_number, out_data.detected,
                             out_data.stable_map, out_data.last));
      end else begin
        want = due_changes.pop_front();
        if (out_data.channel_number !== want.channel_number ||
            out_data.detected !== want.detected ||
            out_data.stable_map !== want.stable_map ||
            out_data.last !== want.last) begin
          flag_error($sformatf({"change mismatch: expected ch=%0d det=%0b map=%02h last=%0b,",
                                " got ch=%0d det=%0b map=%02h last=%0b"},
                               want.channel_number, want.detected, want.stable_map,
                               want.last, out_data.channel_number, out_data.detected,
                               out_data.stable_map, out_data.last));
        end
      end
    end
  end

  // Watchdog: end the run if neither side moves an item for too long.
  always @(posedge clk) begin : watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    in_item_t    s;
    logic [7:0]  flip;
    logic [31:0] dt;
    logic [31:0] clock_ms;
    logic [7:0]  last_raw;
    int unsigned span;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CfgDebounce;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_data      = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    hold_req     = 1'b0;
    error_count  = 0;
    hold_ms      = DebounceRst;
    ch_count     = ChCountRst;
    detect_lvl   = DetectRst;
    seen_raw     = '0;
    settled      = '0;
    loaded       = 1'b0;
    for (int i = 0; i < Channels; i++) moved_ms[i] = '0;

    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Scripted opening, no idling on either side
    for (int r = 0; r < NumRows; r++) begin
      if (Script[r].kind == RowCfg) begin
        write_reg(Script[r].reg_idx, Script[r].reg_val);
      end else begin
        offer(Script[r].sample, Script[r].typed, Script[r].typed_n, Script[r].typed_change);
      end
    end

    // Random phases: mostly small bit flips on a clock that advances near the
    // hold time, so changes get stamped, held and accepted; now and then a
    // fresh raw pattern or an arbitrary jump in time.
    clock_ms = 32'd300000;
    last_raw = 8'h81;
    for (int p = 0; p < NumPhases; p++) begin
      write_reg(CfgDebounce, Phases[p].hold);
      write_reg(CfgChCount, {12'($urandom), Phases[p].count});
      write_reg(CfgDetect, {15'($urandom), Phases[p].detect});
      idle_pct  = Phases[p].idle;
      stall_pct <= Phases[p].stall;
      hold_req  <= Phases[p].pressure;
      span = Phases[p].hold;
      for (int k = 0; k < Phases[p].items; k++) begin
        flip = '0;
        for (int b = 0; b < 8; b++) begin
          if ($urandom_range(7) == 0) flip[b] = 1'b1;
        end
        s.raw_levels = ($urandom_range(3) == 0) ? 8'($urandom) : (last_raw ^ flip);
        case ($urandom_range(9))
          0, 1:       dt = '0;
          2, 3, 4, 5: dt = $urandom_range(span / 2 + 1);
          6, 7:       dt = span + $urandom_range(2);
          8:          dt = $urandom_range(4 * span + 4);
          default:    dt = $urandom;
        endcase
        clock_ms = clock_ms + dt;
        s.now_ms = clock_ms;
        last_raw = s.raw_levels;
        offer(s, 1'b0, 4'd0, '0);
      end
    end

    settle();
    if (due_changes.size() != 0) flag_error("change items still outstanding at end of run");
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/mcd_pkg.sv
design/mcd_ctrl.sv
design/mcd_dp.sv
design/multi_channel_debouncer.sv
dv/multi_channel_debouncer_test.sv
